>>> src/window_median_filter_core_assert.svh
// Assertion macros used by the core RTL file.
`ifndef WINDOW_MEDIAN_FILTER_CORE_ASSERT_SVH
`define WINDOW_MEDIAN_FILTER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Check that an expression holds at every clock edge outside reset.
`define WMF_ASSERT_HOLD(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("window median filter: invariant violated");
// Check that a condition implies a consequence in the same cycle.
`define WMF_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("window median filter: implication violated");
`else
`define WMF_ASSERT_HOLD(lbl, clk, rst, expr)
`define WMF_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`endif
`endif

>>> src/wmf_pkg.sv
`default_nettype none
package wmf_pkg;
   localparam int DEF_MAX_WINDOW = 7;
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int HEIGHT_CAP     = 1024;
   localparam int CHAN_W         = 8;
   localparam int COORD_W        = 10;
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 11;

   localparam logic [1:0]  RST_HALF   = 2'd1;
   localparam logic [10:0] RST_WIDTH  = 11'd640;
   localparam logic [10:0] RST_HEIGHT = 11'd480;
   localparam logic        RST_COLOR  = 1'b0;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WINDOW_HALF  = 2'd0,
      CSR_IMAGE_WIDTH  = 2'd1,
      CSR_IMAGE_HEIGHT = 2'd2,
      CSR_COLOR_MODE   = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FETCH,
      S_CAP,
      S_MED,
      S_MDRAIN,
      S_MDEC,
      S_OUT
   } state_type;

   typedef enum logic [1:0] {
      PH_LEFT,
      PH_MED,
      PH_RIGHT,
      PH_SELF
   } phase_type;

   typedef struct packed {
      logic       init;
      logic       count_en;
      logic       decide;
      logic [2:0] bit_idx;
   } lane_ctl_type;
endpackage
`default_nettype wire

>>> src/window_median_filter_core.sv
`default_nettype none
// Channel   Handshake             Payload
// req       req_valid/req_stall   req_pix_ch0..2
// rsp       rsp_valid/rsp_stall   rsp_out_row, rsp_out_col, rsp_out_ch0..2, rsp_run_last
// csr       csr_valid/csr_ready   csr_index, csr_data
//
// A pixel is written to the line store in the cycle it is accepted; the block then
// stalls req until its results are handed to the output register.
// Median pixels take 8 passes (S_MED reads n = (2h+1)^2 samples, one line store read
// per cycle, then S_MDRAIN, S_MDEC); border results go through S_FETCH, S_CAP, S_OUT.
// Synchronous active-high reset clears control; the line store is not cleared.
// A stalled rsp holds the output register; the sequencer waits for it to drain.
module window_median_filter_core #(
   parameter int MAX_WINDOW = wmf_pkg::DEF_MAX_WINDOW,
   parameter int MAX_WIDTH  = wmf_pkg::DEF_MAX_WIDTH
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [7:0]                         req_pix_ch0,
   input  wire logic [7:0]                         req_pix_ch1,
   input  wire logic [7:0]                         req_pix_ch2,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [wmf_pkg::COORD_W-1:0]             rsp_out_row,
   output logic [wmf_pkg::COORD_W-1:0]             rsp_out_col,
   output logic [7:0]                              rsp_out_ch0,
   output logic [7:0]                              rsp_out_ch1,
   output logic [7:0]                              rsp_out_ch2,
   output logic                                    rsp_run_last,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [wmf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [wmf_pkg::CSR_DATA_W-1:0]     csr_data
);
`include "window_median_filter_core_assert.svh"

   localparam int WW     = $clog2(MAX_WIDTH + 1);
   localparam int SW     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int DEPTH  = MAX_WINDOW * MAX_WIDTH;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
   localparam int HMAX   = (MAX_WINDOW - 1) / 2;
   localparam int RW     = 10;

   function automatic logic [SW-1:0] slot_back(input logic [SW-1:0] s, input logic [2:0] d);
      logic [SW+2:0] t;
      t = {3'b000, s} + (SW+3)'(MAX_WINDOW) - (SW+3)'(d);
      if (t >= (SW+3)'(MAX_WINDOW)) begin
         t = t - (SW+3)'(MAX_WINDOW);
      end
      return t[SW-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] st_addr(input logic [SW-1:0] s, input logic [WW-1:0] c);
      return ADDR_W'(s) * ADDR_W'(MAX_WIDTH) + ADDR_W'(c);
   endfunction

   // configuration registers
   logic [1:0]  cfg_half_ff;
   logic [10:0] cfg_width_ff, cfg_height_ff;
   logic        cfg_color_ff;

   // frame position
   logic [WW-1:0] col_count_ff;
   logic [RW-1:0] row_count_ff;
   logic [SW-1:0] row_slot_ff;

   // effective geometry
   logic [WW-1:0] eff_w;
   logic [10:0]   eff_h;
   logic [1:0]    hsat, eff_half;
   logic [2:0]    span_sat, span, h2;
   logic [CNT_W-1:0] k_init;

   wmf_pkg::state_type state_ff, state_in;
   wmf_pkg::phase_type phase_ff;

   logic accept, out_free, load_out;
   logic do_left, do_med, do_right, do_self;
   logic right_ff, self_ff;

   logic [23:0]   px_ff, emit_px_ff;
   logic [RW-1:0] px_row_ff, row_r_ff;
   logic [WW-1:0] px_col_ff, cur_col_ff, left_ff;
   logic [SW-1:0] slot_r_ff, top_slot_ff, ms_ff;
   logic [2:0]    mi_ff, mj_ff, span_ff, bit_ff;
   logic [1:0]    h_ff;
   logic          rd_vld_ff;
   logic          med_last;

   logic                ram_rd_en;
   logic [ADDR_W-1:0]   ram_rd_addr;
   logic [23:0]         ram_rd_data;
   wmf_pkg::lane_ctl_type lane_ctl;
   logic [7:0]          med0, med1, med2;
   logic [23:0]         emit_data;
   logic                last_flag;

   logic                 rsp_valid_ff;
   logic [RW-1:0]        rsp_row_ff;
   logic [RW-1:0]        rsp_col_ff;
   logic [23:0]          rsp_px_ff;
   logic                 rsp_last_ff;

   // effective width, height and half window
   always_comb begin
      if (cfg_width_ff == 11'd0) begin
         eff_w = WW'(1);
      end else if (32'(cfg_width_ff) > MAX_WIDTH) begin
         eff_w = WW'(MAX_WIDTH);
      end else begin
         eff_w = WW'(cfg_width_ff);
      end
      if (cfg_height_ff == 11'd0) begin
         eff_h = 11'd1;
      end else if (32'(cfg_height_ff) > wmf_pkg::HEIGHT_CAP) begin
         eff_h = 11'(wmf_pkg::HEIGHT_CAP);
      end else begin
         eff_h = cfg_height_ff;
      end
      hsat     = (32'(cfg_half_ff) > HMAX) ? 2'(HMAX) : cfg_half_ff;
      span_sat = {hsat, 1'b1};
      if ((32'(eff_w) < 32'(span_sat)) || (eff_h < 11'(span_sat))) begin
         eff_half = 2'd0;
      end else begin
         eff_half = hsat;
      end
      span   = {eff_half, 1'b1};
      h2     = {eff_half, 1'b0};
      k_init = CNT_W'((6'(span) * 6'(span)) >> 1);
   end

   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   // result plan for the arriving pixel
   always_comb begin
      do_med   = (row_count_ff >= RW'(h2)) && (col_count_ff >= WW'(h2));
      do_left  = (row_count_ff >= RW'(h2)) && (col_count_ff >= WW'(eff_half))
                 && (col_count_ff < WW'(h2));
      do_right = do_med && (col_count_ff == eff_w - WW'(1)) && (eff_half != 2'd0);
      do_self  = (row_count_ff < RW'(eff_half))
                 || ({1'b0, row_count_ff} >= eff_h - 11'(eff_half));
   end

   assign med_last = (mi_ff == span_ff - 3'd1) && (mj_ff == span_ff - 3'd1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wmf_pkg::S_IDLE: begin
            if (accept) begin
               if (do_left) begin
                  state_in = wmf_pkg::S_FETCH;
               end else if (do_med) begin
                  state_in = wmf_pkg::S_MED;
               end else if (do_self) begin
                  state_in = wmf_pkg::S_OUT;
               end
            end
         end
         wmf_pkg::S_FETCH:  state_in = wmf_pkg::S_CAP;
         wmf_pkg::S_CAP:    state_in = wmf_pkg::S_OUT;
         wmf_pkg::S_MED: begin
            if (med_last) begin
               state_in = wmf_pkg::S_MDRAIN;
            end
         end
         wmf_pkg::S_MDRAIN: state_in = wmf_pkg::S_MDEC;
         wmf_pkg::S_MDEC: begin
            state_in = (bit_ff == 3'd0) ? wmf_pkg::S_OUT : wmf_pkg::S_MED;
         end
         wmf_pkg::S_OUT: begin
            if (out_free) begin
               case (phase_ff)
                  wmf_pkg::PH_LEFT:
                     state_in = self_ff ? wmf_pkg::S_OUT : wmf_pkg::S_IDLE;
                  wmf_pkg::PH_MED:
                     state_in = right_ff ? wmf_pkg::S_FETCH
                              : (self_ff ? wmf_pkg::S_OUT : wmf_pkg::S_IDLE);
                  wmf_pkg::PH_RIGHT:
                     state_in = (cur_col_ff != eff_w - WW'(1)) ? wmf_pkg::S_FETCH
                              : (self_ff ? wmf_pkg::S_OUT : wmf_pkg::S_IDLE);
                  default: state_in = wmf_pkg::S_IDLE;
               endcase
            end
         end
         default: state_in = wmf_pkg::S_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall        = (state_ff != wmf_pkg::S_IDLE);
      ram_rd_en        = 1'b0;
      ram_rd_addr      = st_addr(slot_r_ff, cur_col_ff);
      lane_ctl.init    = accept && do_med;
      lane_ctl.count_en = rd_vld_ff;
      lane_ctl.decide  = (state_ff == wmf_pkg::S_MDEC);
      lane_ctl.bit_idx = bit_ff;
      load_out         = 1'b0;
      case (state_ff)
         wmf_pkg::S_FETCH: ram_rd_en = 1'b1;
         wmf_pkg::S_MED: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = st_addr(ms_ff, left_ff + WW'(mj_ff));
         end
         wmf_pkg::S_OUT: load_out = out_free;
         default: ram_rd_en = 1'b0;
      endcase
      emit_data = (phase_ff == wmf_pkg::PH_MED) ? {med2, med1, med0} : emit_px_ff;
      case (phase_ff)
         wmf_pkg::PH_LEFT:  last_flag = !self_ff;
         wmf_pkg::PH_MED:   last_flag = !right_ff && !self_ff;
         wmf_pkg::PH_RIGHT: last_flag = (cur_col_ff == eff_w - WW'(1)) && !self_ff;
         default:           last_flag = 1'b1;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= wmf_pkg::S_IDLE;
         rd_vld_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         col_count_ff  <= '0;
         row_count_ff  <= '0;
         row_slot_ff   <= '0;
         cfg_half_ff   <= wmf_pkg::RST_HALF;
         cfg_width_ff  <= wmf_pkg::RST_WIDTH;
         cfg_height_ff <= wmf_pkg::RST_HEIGHT;
         cfg_color_ff  <= wmf_pkg::RST_COLOR;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= (state_ff == wmf_pkg::S_MED);
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            case (wmf_pkg::csr_index_type'(csr_index))
               wmf_pkg::CSR_WINDOW_HALF:  cfg_half_ff   <= csr_data[1:0];
               wmf_pkg::CSR_IMAGE_WIDTH:  cfg_width_ff  <= csr_data;
               wmf_pkg::CSR_IMAGE_HEIGHT: cfg_height_ff <= csr_data;
               wmf_pkg::CSR_COLOR_MODE:   cfg_color_ff  <= csr_data[0];
               default:                   cfg_color_ff  <= cfg_color_ff;
            endcase
            // restart the frame on any register write
            col_count_ff <= '0;
            row_count_ff <= '0;
            row_slot_ff  <= '0;
         end else if (accept) begin
            if (col_count_ff + WW'(1) >= eff_w) begin
               col_count_ff <= '0;
               if ({1'b0, row_count_ff} + 11'd1 >= eff_h) begin
                  row_count_ff <= '0;
                  row_slot_ff  <= '0;
               end else begin
                  row_count_ff <= row_count_ff + RW'(1);
                  row_slot_ff  <= (row_slot_ff == SW'(MAX_WINDOW - 1)) ? '0
                                  : row_slot_ff + SW'(1);
               end
            end else begin
               col_count_ff <= col_count_ff + WW'(1);
            end
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         px_ff       <= {req_pix_ch2, req_pix_ch1, req_pix_ch0};
         emit_px_ff  <= {req_pix_ch2, req_pix_ch1, req_pix_ch0};
         px_row_ff   <= row_count_ff;
         px_col_ff   <= col_count_ff;
         row_r_ff    <= row_count_ff - RW'(eff_half);
         cur_col_ff  <= col_count_ff - WW'(eff_half);
         left_ff     <= col_count_ff - WW'(h2);
         slot_r_ff   <= slot_back(row_slot_ff, {1'b0, eff_half});
         top_slot_ff <= slot_back(row_slot_ff, h2);
         ms_ff       <= slot_back(row_slot_ff, h2);
         mi_ff       <= 3'd0;
         mj_ff       <= 3'd0;
         bit_ff      <= 3'd7;
         span_ff     <= span;
         h_ff        <= eff_half;
         right_ff    <= do_right;
         self_ff     <= do_self;
         phase_ff    <= do_left ? wmf_pkg::PH_LEFT
                      : (do_med ? wmf_pkg::PH_MED : wmf_pkg::PH_SELF);
      end
      case (state_ff)
         wmf_pkg::S_CAP: emit_px_ff <= ram_rd_data;
         wmf_pkg::S_MED: begin
            // walk the window row by row
            if (mj_ff == span_ff - 3'd1) begin
               mj_ff <= 3'd0;
               mi_ff <= mi_ff + 3'd1;
               ms_ff <= (ms_ff == SW'(MAX_WINDOW - 1)) ? '0 : ms_ff + SW'(1);
            end else begin
               mj_ff <= mj_ff + 3'd1;
            end
         end
         wmf_pkg::S_MDEC: begin
            mi_ff <= 3'd0;
            mj_ff <= 3'd0;
            ms_ff <= top_slot_ff;
            if (bit_ff != 3'd0) begin
               bit_ff <= bit_ff - 3'd1;
            end
         end
         wmf_pkg::S_OUT: begin
            if (out_free) begin
               case (phase_ff)
                  wmf_pkg::PH_MED: begin
                     if (right_ff) begin
                        phase_ff   <= wmf_pkg::PH_RIGHT;
                        cur_col_ff <= eff_w - WW'(h_ff);
                     end else begin
                        phase_ff   <= wmf_pkg::PH_SELF;
                        emit_px_ff <= px_ff;
                     end
                  end
                  wmf_pkg::PH_RIGHT: begin
                     if (cur_col_ff != eff_w - WW'(1)) begin
                        cur_col_ff <= cur_col_ff + WW'(1);
                     end else begin
                        phase_ff   <= wmf_pkg::PH_SELF;
                        emit_px_ff <= px_ff;
                     end
                  end
                  default: begin
                     phase_ff   <= wmf_pkg::PH_SELF;
                     emit_px_ff <= px_ff;
                  end
               endcase
            end
         end
         default: begin
         end
      endcase
      // load the output register, zero the upper channels in grayscale
      if (load_out) begin
         rsp_row_ff  <= (phase_ff == wmf_pkg::PH_SELF) ? px_row_ff : row_r_ff;
         rsp_col_ff  <= (phase_ff == wmf_pkg::PH_SELF) ? RW'(px_col_ff) : RW'(cur_col_ff);
         rsp_px_ff   <= cfg_color_ff ? emit_data : {16'd0, emit_data[7:0]};
         rsp_last_ff <= last_flag;
      end
   end

   wmf_ram #(
      .WIDTH (24),
      .DEPTH (DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (st_addr(row_slot_ff, col_count_ff)),
      .wr_data ({req_pix_ch2, req_pix_ch1, req_pix_ch0}),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   wmf_rank_lane #(.CNT_W(CNT_W)) u_lane0 (
      .clock (clock), .ctl (lane_ctl), .k_init (k_init),
      .sample (ram_rd_data[7:0]), .result (med0)
   );
   wmf_rank_lane #(.CNT_W(CNT_W)) u_lane1 (
      .clock (clock), .ctl (lane_ctl), .k_init (k_init),
      .sample (ram_rd_data[15:8]), .result (med1)
   );
   wmf_rank_lane #(.CNT_W(CNT_W)) u_lane2 (
      .clock (clock), .ctl (lane_ctl), .k_init (k_init),
      .sample (ram_rd_data[23:16]), .result (med2)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_row  = rsp_row_ff;
   assign rsp_out_col  = rsp_col_ff;
   assign rsp_out_ch0  = rsp_px_ff[7:0];
   assign rsp_out_ch1  = rsp_px_ff[15:8];
   assign rsp_out_ch2  = rsp_px_ff[23:16];
   assign rsp_run_last = rsp_last_ff;

   // all counts of a pass are in before the bit is decided
   `WMF_ASSERT_IMPL(a_drain_before_decide, clock, reset, state_ff == wmf_pkg::S_MDEC, !rd_vld_ff)
   // never overwrite a result that is still stalled
   `WMF_ASSERT_IMPL(a_no_overwrite, clock, reset, load_out, !(rsp_valid_ff && rsp_stall))
   // the column counter stays inside the frame
   `WMF_ASSERT_HOLD(a_col_in_frame, clock, reset, col_count_ff < eff_w)
endmodule
`default_nettype wire

>>> src/wmf_ram.sv
`default_nettype none
module wmf_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 7168
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

>>> src/wmf_rank_lane.sv
`default_nettype none
// Radix select of the k-th smallest sample, one bit per pass.
module wmf_rank_lane #(
   parameter int CNT_W = 6
) (
   input  wire logic                  clock,
   input  wire wmf_pkg::lane_ctl_type ctl,
   input  wire logic [CNT_W-1:0]      k_init,
   input  wire logic [7:0]            sample,
   output logic      [7:0]            result
);
   logic [7:0]       prefix_ff, prefix_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0]       hi_mask;
   logic [3:0]       shamt;
   logic             match;

   always_comb begin
      shamt   = {1'b0, ctl.bit_idx} + 4'd1;
      hi_mask = 8'hFF << shamt;
      match   = (((sample ^ prefix_ff) & hi_mask) == 8'd0) && !sample[ctl.bit_idx];
      prefix_in = prefix_ff;
      k_in      = k_ff;
      cnt_in    = cnt_ff;
      if (ctl.init) begin
         prefix_in = 8'd0;
         k_in      = k_init;
         cnt_in    = '0;
      end else if (ctl.decide) begin
         // keep bit low when the rank falls among the zero-bit candidates
         if (k_ff >= cnt_ff) begin
            prefix_in[ctl.bit_idx] = 1'b1;
            k_in = k_ff - cnt_ff;
         end
         cnt_in = '0;
      end else if (ctl.count_en && match) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      prefix_ff <= prefix_in;
      k_ff      <= k_in;
      cnt_ff    <= cnt_in;
   end

   assign result = prefix_ff;
endmodule
`default_nettype wire

>>> tb/sv/window_median_filter_core_test.sv
`default_nettype none
module window_median_filter_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_WIN   = wmf_pkg::DEF_MAX_WINDOW;
   localparam int MAX_COLS  = wmf_pkg::DEF_MAX_WIDTH;
   localparam int WAIT_IDLE = 600;    // covers a 7x7 median
   localparam int STALL_CAP = 6000;   // cycles without any transaction

   typedef struct {
      logic [wmf_pkg::COORD_W-1:0] row;
      logic [wmf_pkg::COORD_W-1:0] col;
      logic [7:0]                  ch0;
      logic [7:0]                  ch1;
      logic [7:0]                  ch2;
      logic                        last;
   } pixel_out_type;

   typedef struct {
      logic [7:0] ch0;
      logic [7:0] ch1;
      logic [7:0] ch2;
   } pixel_in_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_pix_ch0 = '0;
   logic [7:0] req_pix_ch1 = '0;
   logic [7:0] req_pix_ch2 = '0;

   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [wmf_pkg::COORD_W-1:0] rsp_out_row;
   logic [wmf_pkg::COORD_W-1:0] rsp_out_col;
   logic [7:0]                  rsp_out_ch0;
   logic [7:0]                  rsp_out_ch1;
   logic [7:0]                  rsp_out_ch2;
   logic                        rsp_run_last;

   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [wmf_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [wmf_pkg::CSR_DATA_W-1:0]  csr_data  = '0;

   // pixels waiting for the driver, and filter outputs still owed by the block
   pixel_in_type  pixel_queue[$];
   pixel_out_type filtered_queue[$];

   int fail_count   = 0;
   int pixels_sent  = 0;
   int pixels_out   = 0;
   int csr_writes   = 0;
   int quiet_cycles = 0;
   bit calm         = 1'b0;   // set for a stretch with no idling on either side

   // shadow of the block: its line store, raster position and registers
   logic [23:0]      line_mem [MAX_WIN*MAX_COLS];
   int unsigned      cur_row, cur_col;
   logic [1:0]       half_reg;
   logic [10:0]      width_reg, height_reg;
   logic             color_reg;

   window_median_filter_core i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_pix_ch0  (req_pix_ch0),
      .req_pix_ch1  (req_pix_ch1),
      .req_pix_ch2  (req_pix_ch2),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_row  (rsp_out_row),
      .rsp_out_col  (rsp_out_col),
      .rsp_out_ch0  (rsp_out_ch0),
      .rsp_out_ch1  (rsp_out_ch1),
      .rsp_out_ch2  (rsp_out_ch2),
      .rsp_run_last (rsp_run_last),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   always #6 clock = ~clock;

   function automatic logic [23:0] line_read(int unsigned row, int unsigned col);
      int unsigned idx;
      idx = (row % MAX_WIN) * MAX_COLS + col;
      return (idx < MAX_WIN*MAX_COLS) ? line_mem[idx] : 24'd0;
   endfunction

   // Median of one byte lane over the (2h+1)^2 window with its corner at top/left.
   function automatic logic [7:0] lane_median(int unsigned top, int unsigned left,
                                              int unsigned h, int unsigned lane);
      logic [7:0]  vals [MAX_WIN*MAX_WIN];
      logic [7:0]  key;
      logic [23:0] word;
      int unsigned span, n, j;
      span = 2*h + 1;
      n = 0;
      for (int unsigned i = 0; i < span; i++) begin
         for (int unsigned k = 0; k < span; k++) begin
            word = line_read(top + i, left + k);
            vals[n] = word[lane*8 +: 8];
            n++;
         end
      end
      for (int unsigned i = 1; i < n; i++) begin
         key = vals[i];
         j = i;
         while (j > 0 && vals[j-1] > key) begin
            vals[j] = vals[j-1];
            j--;
         end
         vals[j] = key;
      end
      return vals[n/2];
   endfunction

   function automatic pixel_out_type make_out(int unsigned row, int unsigned col,
                                              logic [23:0] px);
      pixel_out_type o;
      o.row  = row[wmf_pkg::COORD_W-1:0];
      o.col  = col[wmf_pkg::COORD_W-1:0];
      o.ch0  = px[7:0];
      o.ch1  = color_reg ? px[15:8]  : 8'd0;
      o.ch2  = color_reg ? px[23:16] : 8'd0;
      o.last = 1'b0;
      return o;
   endfunction

   // Advance the shadow by one accepted pixel and queue the outputs it releases.
   task automatic filter_pixel(pixel_in_type p);
      pixel_out_type outs[$];
      int unsigned   w, ht, h, r, c, rr, top, left;
      logic [23:0]   px, med;
      w  = (width_reg == 0) ? 1 : (width_reg > MAX_COLS ? MAX_COLS : width_reg);
      ht = (height_reg == 0) ? 1
         : (height_reg > wmf_pkg::HEIGHT_CAP ? wmf_pkg::HEIGHT_CAP : height_reg);
      h  = half_reg;
      if (h > (MAX_WIN - 1) / 2) h = (MAX_WIN - 1) / 2;
      if (w < 2*h + 1 || ht < 2*h + 1) h = 0;
      if (cur_col >= w || cur_row >= ht) begin
         cur_row = 0;
         cur_col = 0;
      end
      r  = cur_row;
      c  = cur_col;
      px = {p.ch2, p.ch1, p.ch0};
      line_mem[(r % MAX_WIN) * MAX_COLS + c] = px;
      if (r >= 2*h) begin
         rr = r - h;
         if (c >= h && c < 2*h) begin
            outs.insert(outs.size(), make_out(rr, c - h, line_read(rr, c - h)));
         end else if (c >= 2*h) begin
            top  = r - 2*h;
            left = c - 2*h;
            med  = {lane_median(top, left, h, 2), lane_median(top, left, h, 1),
                    lane_median(top, left, h, 0)};
            outs.insert(outs.size(), make_out(rr, c - h, med));
            if (c == w - 1) begin
               for (int unsigned k = w - h; k < w; k++)
                  outs.insert(outs.size(), make_out(rr, k, line_read(rr, k)));
            end
         end
      end
      if (r < h || r >= ht - h) outs.insert(outs.size(), make_out(r, c, px));
      if (outs.size() > 0) outs[outs.size()-1].last = 1'b1;
      foreach (outs[i]) filtered_queue.insert(filtered_queue.size(), outs[i]);
      cur_col = c + 1;
      if (cur_col >= w) begin
         cur_col = 0;
         cur_row = r + 1;
         if (cur_row >= ht) cur_row = 0;
      end
   endtask

   // Driver: hold a stalled pixel, otherwise advance to the next one or idle.
   always @(posedge clock) begin
      logic         take, go;
      pixel_in_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         take = req_valid && !req_stall;
         if (take) begin
            filter_pixel(pixel_queue.pop_front());
            pixels_sent++;
         end
         if (req_valid && !take) begin
            go = 1'b1;
         end else begin
            go = pixel_queue.size() > 0 && (calm || $urandom_range(99) >= 33);
            if (go) begin
               nxt = pixel_queue[0];
               req_pix_ch0 <= nxt.ch0;
               req_pix_ch1 <= nxt.ch1;
               req_pix_ch2 <= nxt.ch2;
            end
         end
         req_valid <= go;
      end
   end

   // Monitor: check each output transaction against the oldest expectation.
   always @(posedge clock) begin
      pixel_out_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            pixels_out++;
            if (filtered_queue.size() == 0) begin
               $error("unexpected output pixel row %0d col %0d", rsp_out_row, rsp_out_col);
               fail_count++;
            end else begin
               e = filtered_queue.pop_front();
               if (rsp_out_row !== e.row) begin
                  $error("out_row: expected %0d, got %0d", e.row, rsp_out_row);
                  fail_count++;
               end
               if (rsp_out_col !== e.col) begin
                  $error("out_col: expected %0d, got %0d", e.col, rsp_out_col);
                  fail_count++;
               end
               if (rsp_out_ch0 !== e.ch0) begin
                  $error("out_ch0: expected %0d, got %0d", e.ch0, rsp_out_ch0);
                  fail_count++;
               end
               if (rsp_out_ch1 !== e.ch1) begin
                  $error("out_ch1: expected %0d, got %0d", e.ch1, rsp_out_ch1);
                  fail_count++;
               end
               if (rsp_out_ch2 !== e.ch2) begin
                  $error("out_ch2: expected %0d, got %0d", e.ch2, rsp_out_ch2);
                  fail_count++;
               end
               if (rsp_run_last !== e.last) begin
                  $error("run_last: expected %0d, got %0d", e.last, rsp_run_last);
                  fail_count++;
               end
            end
         end
         rsp_stall <= !calm && $urandom_range(99) < 33;
      end
   end

   // Watchdog: end the run when no transaction moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_CAP) begin
         $display("window_median_filter_core verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Drain all pending work, then let an output-free median finish.
   task automatic settle();
      while (pixel_queue.size() > 0 || req_valid || filtered_queue.size() > 0)
         @(posedge clock);
      repeat (WAIT_IDLE) @(posedge clock);
   endtask

   // Write one register while the block is idle; any write restarts the frame.
   task automatic write_reg(wmf_pkg::csr_index_type idx,
                            logic [wmf_pkg::CSR_DATA_W-1:0] val);
      settle();
      csr_index <= idx;
      csr_data  <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         wmf_pkg::CSR_WINDOW_HALF:  half_reg   = val[1:0];
         wmf_pkg::CSR_IMAGE_WIDTH:  width_reg  = val;
         wmf_pkg::CSR_IMAGE_HEIGHT: height_reg = val;
         wmf_pkg::CSR_COLOR_MODE:   color_reg  = val[0];
         default: ;
      endcase
      cur_row = 0;
      cur_col = 0;
      csr_writes++;
   endtask

   task automatic setup(logic [1:0] h, logic [10:0] w, logic [10:0] ht, logic cm);
      write_reg(wmf_pkg::CSR_WINDOW_HALF, 11'(h));
      write_reg(wmf_pkg::CSR_IMAGE_WIDTH, w);
      write_reg(wmf_pkg::CSR_IMAGE_HEIGHT, ht);
      write_reg(wmf_pkg::CSR_COLOR_MODE, 11'(cm));
   endtask

   task automatic push_random(int count);
      pixel_in_type p;
      repeat (count) begin
         p.ch0 = 8'($urandom);
         p.ch1 = 8'($urandom);
         p.ch2 = 8'($urandom);
         pixel_queue.insert(pixel_queue.size(), p);
      end
   endtask

   initial begin
      pixel_in_type p;
      cur_row    = 0;
      cur_col    = 0;
      half_reg   = wmf_pkg::RST_HALF;
      width_reg  = wmf_pkg::RST_WIDTH;
      height_reg = wmf_pkg::RST_HEIGHT;
      color_reg  = wmf_pkg::RST_COLOR;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset settings: top rows pass straight through; drive channel extremes
      for (int i = 0; i < 8; i++) begin
         p.ch0 = (i & 1) ? 8'hFF : 8'h00;
         p.ch1 = (i & 2) ? 8'hFF : 8'h00;
         p.ch2 = (i & 4) ? 8'hFF : 8'h00;
         pixel_queue.insert(pixel_queue.size(), p);
      end
      push_random(4);

      // color mode with no window, then window taller than the frame
      setup(2'd0, 11'd8, 11'd8, 1'b1);
      push_random(6);
      setup(2'd3, 11'd8, 11'd6, 1'b1);
      push_random(6);

      // out-of-range sizes: zero acts as one, oversize clips to the maximum
      setup(2'd1, 11'd0, 11'd0, 1'b0);
      push_random(4);
      setup(2'd2, 11'd2047, 11'd2047, 1'b1);
      push_random(6);
      setup(2'd1, 11'd1024, 11'd1024, 1'b0);
      push_random(4);

      // largest window on a minimal frame, with no idling on either side
      setup(2'd3, 11'd8, 11'd8, 1'b1);
      calm = 1'b1;
      push_random(64);
      settle();
      calm = 1'b0;

      // 3x3 full frame plus a wrap into the next one
      setup(2'd1, 11'd8, 11'd8, 1'b1);
      push_random(72);

      // 5x5 grayscale on a wider frame, left mid-frame by the next write
      setup(2'd2, 11'd12, 11'd9, 1'b0);
      push_random(70);

      // restart mid-frame with a single register write
      write_reg(wmf_pkg::CSR_COLOR_MODE, 11'd1);
      push_random(20);

      settle();
      $display("checked %0d pixels in, %0d pixels out, %0d register writes",
               pixels_sent, pixels_out, csr_writes);
      $display("window sizes 1x1 to 7x7, gray and color, size clipping and frame wrap");
      if (fail_count == 0 && filtered_queue.size() == 0) begin
         $display("window_median_filter_core verification clean");
      end else begin
         $display("window_median_filter_core verification failed");
      end
      $finish;
   end
endmodule
`default_nettype wire
